// ===== design/assert_macros.svh =====
// Assertion macros shared by the sorted key set design.
// Depends on nothing; users must provide clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that a property holds at every clock edge outside reset.
`define SKS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checks that a condition in one cycle is followed by a consequence in the next.
`define SKS_ASSERT_NEXT(label, cond, conseq, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (conseq)) \
    else $error(msg);

`endif

// ===== design/sks_pkg.sv =====
// Shared types and constants for the sorted key set.
// Depends on nothing; used by the controller, the datapath and the top level.
package sks_pkg;

  localparam int unsigned KeyW    = 64;
  localparam int unsigned OpW     = 2;
  localparam int unsigned PosW    = 6;
  localparam int unsigned CountW  = 7;
  localparam int unsigned InDataW = 72;
  localparam int unsigned OutDataW = 16;

  localparam logic [OpW-1:0] OP_CONTAINS = 2'd0;
  localparam logic [OpW-1:0] OP_INSERT   = 2'd1;
  localparam logic [OpW-1:0] OP_ERASE    = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SRCH_RD,
    ST_SRCH_CMP,
    ST_DECIDE,
    ST_SHIFT_RD,
    ST_SHIFT_WR,
    ST_PLACE,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic load;
    logic rd_search;
    logic idx_inc;
    logic latch_pos;
    logic latch_found;
    logic init_ins;
    logic init_era;
    logic rd_shift;
    logic wr_shift;
    logic place;
    logic set_reject;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic idx_end;
    logic key_ge;
    logic key_eq;
    logic found;
    logic full;
    logic is_insert;
    logic is_erase;
    logic shift_more;
    logic out_free;
  } status_t;

endpackage

// ===== design/sorted_key_set_top.sv =====
// Each accepted word is searched past the p keys below its key, then an insert or erase shifts
// the m keys it moves, and the result word is registered.
// One word at a time; the next is taken the cycle after the result is registered, and out_tready
// can hold the result back, and with it the next word.
// Reset (rst_n low, synchronous) empties the set; key entries are read only once written.
// Depends on sks_pkg, sks_ctrl, sks_dp and assert_macros.svh.
`include "assert_macros.svh"

module sorted_key_set_top #(
  parameter int unsigned CAPACITY = 64
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  // Fields from bit 0: operation[1:0], key[65:2], zero padding[71:66].
  input  logic [sks_pkg::InDataW-1:0]   in_tdata,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // Fields from bit 0: found[0], position[6:1], changed[7], full_reject[8], count[15:9].
  output logic [sks_pkg::OutDataW-1:0]  out_tdata
);

  sks_pkg::cmd_t    cmd;
  sks_pkg::status_t status;
  sks_pkg::state_t  state;

  sks_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .status    (status),
    .cmd       (cmd),
    .state     (state)
  );

  sks_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .status     (status),
    .in_tdata   (in_tdata),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata)
  );

  `SKS_ASSERT_NEXT(a_busy_after_accept, in_tvalid && in_tready, !in_tready, "input taken while busy")
  `SKS_ASSERT(a_change_or_reject, !(out_tvalid && out_tdata[7] && out_tdata[8]), "changed and rejected together")
  `SKS_ASSERT(a_result_from_work, !$rose(out_tvalid) || $past(state == sks_pkg::ST_DONE), "result without work")
  `SKS_ASSERT(a_store_write_busy, !((cmd.wr_shift || cmd.place) && in_tready), "store written while idle")

endmodule

// ===== design/sks_ctrl.sv =====
// Controller state machine for the sorted key set.
// Depends on sks_pkg; drives the datapath commands from its status.
module sks_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  sks_pkg::status_t status,
  output sks_pkg::cmd_t    cmd,
  output sks_pkg::state_t  state
);

  sks_pkg::state_t state_r;
  sks_pkg::state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sks_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      sks_pkg::ST_IDLE: begin
        if (in_tvalid) state_nxt = sks_pkg::ST_SRCH_RD;
      end
      sks_pkg::ST_SRCH_RD: begin
        state_nxt = status.idx_end ? sks_pkg::ST_DECIDE : sks_pkg::ST_SRCH_CMP;
      end
      sks_pkg::ST_SRCH_CMP: begin
        state_nxt = status.key_ge ? sks_pkg::ST_DECIDE : sks_pkg::ST_SRCH_RD;
      end
      sks_pkg::ST_DECIDE: begin
        if ((status.is_insert && !status.found && !status.full) ||
            (status.is_erase && status.found)) begin
          state_nxt = sks_pkg::ST_SHIFT_RD;
        end else begin
          state_nxt = sks_pkg::ST_DONE;
        end
      end
      sks_pkg::ST_SHIFT_RD: begin
        state_nxt = status.shift_more ? sks_pkg::ST_SHIFT_WR : sks_pkg::ST_PLACE;
      end
      sks_pkg::ST_SHIFT_WR: begin
        state_nxt = sks_pkg::ST_SHIFT_RD;
      end
      sks_pkg::ST_PLACE: begin
        state_nxt = sks_pkg::ST_DONE;
      end
      sks_pkg::ST_DONE: begin
        if (status.out_free) state_nxt = sks_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = sks_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      sks_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        cmd.load  = in_tvalid;
      end
      sks_pkg::ST_SRCH_RD: begin
        cmd.rd_search = !status.idx_end;
        cmd.latch_pos = status.idx_end;
      end
      sks_pkg::ST_SRCH_CMP: begin
        cmd.latch_pos   = status.key_ge;
        cmd.latch_found = status.key_ge && status.key_eq;
        cmd.idx_inc     = !status.key_ge;
      end
      sks_pkg::ST_DECIDE: begin
        cmd.init_ins   = status.is_insert && !status.found && !status.full;
        cmd.init_era   = status.is_erase && status.found;
        cmd.set_reject = status.is_insert && !status.found && status.full;
      end
      sks_pkg::ST_SHIFT_RD: begin
        cmd.rd_shift = status.shift_more;
      end
      sks_pkg::ST_SHIFT_WR: begin
        cmd.wr_shift = 1'b1;
      end
      sks_pkg::ST_PLACE: begin
        cmd.place = 1'b1;
      end
      sks_pkg::ST_DONE: begin
        cmd.out_load = status.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  assign state = state_r;

endmodule

// ===== design/sks_dp.sv =====
// Datapath for the sorted key set: key store, search and shift counters, result register.
// Depends on sks_pkg; steered by sks_ctrl through command and status structs.
module sks_dp #(
  parameter int unsigned CAPACITY = 64
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  sks_pkg::cmd_t                  cmd,
  output sks_pkg::status_t               status,
  input  logic [sks_pkg::InDataW-1:0]    in_tdata,
  input  logic                           out_tready,
  output logic                           out_tvalid,
  output logic [sks_pkg::OutDataW-1:0]   out_tdata
);

  localparam int unsigned IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam logic [CW-1:0] CapVal = CW'(CAPACITY);

  logic [sks_pkg::KeyW-1:0] mem [CAPACITY];
  logic [sks_pkg::KeyW-1:0] rd_data_r;
  logic [sks_pkg::KeyW-1:0] key_r;
  logic [sks_pkg::OpW-1:0]  op_r;

  logic [CW-1:0] count_r;
  logic [CW-1:0] idx_r;
  logic [CW-1:0] pos_r;
  logic [CW-1:0] j_r;
  logic          mode_ins_r;
  logic          found_r;
  logic          changed_r;
  logic          reject_r;
  logic          out_valid_r;
  logic [sks_pkg::OutDataW-1:0] out_data_r;

  logic [CW-1:0] src_idx;
  logic [CW-1:0] rd_idx;
  logic          rd_en;
  logic [CW-1:0] wr_idx;
  logic [sks_pkg::KeyW-1:0] wr_data;
  logic          wr_en;
  logic [CW-1:0] count_out;
  logic [sks_pkg::PosW-1:0] pos_out;

  assign src_idx = mode_ins_r ? (j_r - CW'(1)) : (j_r + CW'(1));
  assign rd_idx  = cmd.rd_search ? idx_r : src_idx;
  assign rd_en   = cmd.rd_search || cmd.rd_shift;
  assign wr_en   = cmd.wr_shift || (cmd.place && mode_ins_r);
  assign wr_idx  = cmd.wr_shift ? j_r : pos_r;
  assign wr_data = cmd.wr_shift ? rd_data_r : key_r;

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_idx[IW-1:0]];
    end
    if (wr_en) begin
      mem[wr_idx[IW-1:0]] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r  <= in_tdata[sks_pkg::OpW-1:0];
      key_r <= in_tdata[sks_pkg::OpW +: sks_pkg::KeyW];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r    <= '0;
      idx_r      <= '0;
      pos_r      <= '0;
      j_r        <= '0;
      mode_ins_r <= 1'b0;
      found_r    <= 1'b0;
      changed_r  <= 1'b0;
      reject_r   <= 1'b0;
    end else begin
      if (cmd.load) begin
        idx_r     <= '0;
        found_r   <= 1'b0;
        changed_r <= 1'b0;
        reject_r  <= 1'b0;
      end
      if (cmd.idx_inc) idx_r <= idx_r + CW'(1);
      if (cmd.latch_pos) pos_r <= idx_r;
      if (cmd.latch_found) found_r <= 1'b1;
      if (cmd.set_reject) reject_r <= 1'b1;
      if (cmd.init_ins) begin
        mode_ins_r <= 1'b1;
        j_r        <= count_r;
      end
      if (cmd.init_era) begin
        mode_ins_r <= 1'b0;
        j_r        <= pos_r;
      end
      if (cmd.wr_shift) j_r <= src_idx;
      if (cmd.place) begin
        changed_r <= 1'b1;
        count_r   <= mode_ins_r ? (count_r + CW'(1)) : (count_r - CW'(1));
      end
    end
  end

  assign count_out = count_r;
  assign pos_out   = found_r ? sks_pkg::PosW'(pos_r) : '0;

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data_r <= {sks_pkg::CountW'(count_out), reject_r, changed_r, pos_out, found_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_comb begin
    status            = '0;
    status.idx_end    = (idx_r >= count_r);
    status.key_ge     = ($signed(rd_data_r) >= $signed(key_r));
    status.key_eq     = (rd_data_r == key_r);
    status.found      = found_r;
    status.full       = (count_r >= CapVal);
    status.is_insert  = (op_r == sks_pkg::OP_INSERT);
    status.is_erase   = (op_r == sks_pkg::OP_ERASE);
    status.shift_more = mode_ins_r ? (j_r > pos_r) : ((j_r + CW'(1)) < count_r);
    status.out_free   = !out_valid_r || out_tready;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

// ===== tb/sv/tb.sv =====
// Self-checking tb for sorted_key_set_top: contains, insert, erase, unused-op words on signed keys.
// Depends on sks_pkg and the sorted_key_set_top design; a behavioural model of the set, or a fixed
// directed result, gives each expected word, checked field by field under random back-pressure.
module tb;
  import sks_pkg::*;

  localparam int unsigned CAPACITY = 64;
  localparam logic [OpW-1:0] OP_UNUSED = 2'd3;
  localparam logic signed [KeyW-1:0] KEY_MIN = 64'sh8000_0000_0000_0000;
  localparam logic signed [KeyW-1:0] KEY_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam int unsigned POOL_SIZE = 96;
  localparam int unsigned NUM_PHASES = 16;
  localparam int unsigned PHASE_LEN = 97;
  localparam int unsigned DRAIN_CYCLES = 300;
  localparam int unsigned HOLDOFF_CYCLES = 500;

  typedef struct packed {
    logic           found;
    logic [PosW-1:0] position;
    logic           changed;
    logic           full_reject;
    logic [CountW-1:0] count;
  } set_result_t;

  typedef struct packed {
    logic [OpW-1:0]          op;
    logic signed [KeyW-1:0]  key;
    bit                      typed;
    set_result_t             res;
  } dir_row_t;

  typedef enum int {PH_FILL, PH_DRAIN, PH_MIXED} phase_kind_t;

  localparam set_result_t NO_RES = '0;
  localparam int unsigned NUM_DIRECTED = 22;
  localparam dir_row_t DIRECTED [NUM_DIRECTED] = '{
    '{OP_CONTAINS, 64'sd0,        1'b1, '{1'b0, 6'd0, 1'b0, 1'b0, 7'd0}},
    '{OP_ERASE,    64'sd5,        1'b1, '{1'b0, 6'd0, 1'b0, 1'b0, 7'd0}},
    '{OP_UNUSED,   64'sd7,        1'b1, '{1'b0, 6'd0, 1'b0, 1'b0, 7'd0}},
    '{OP_INSERT,   KEY_MAX,       1'b1, '{1'b0, 6'd0, 1'b1, 1'b0, 7'd1}},
    '{OP_INSERT,   KEY_MIN,       1'b1, '{1'b0, 6'd0, 1'b1, 1'b0, 7'd2}},
    '{OP_INSERT,   64'sd0,        1'b1, '{1'b0, 6'd0, 1'b1, 1'b0, 7'd3}},
    '{OP_CONTAINS, KEY_MIN,       1'b1, '{1'b1, 6'd0, 1'b0, 1'b0, 7'd3}},
    '{OP_CONTAINS, KEY_MAX,       1'b1, '{1'b1, 6'd2, 1'b0, 1'b0, 7'd3}},
    '{OP_INSERT,   64'sd0,        1'b1, '{1'b1, 6'd1, 1'b0, 1'b0, 7'd3}},
    '{OP_UNUSED,   KEY_MAX,       1'b1, '{1'b1, 6'd2, 1'b0, 1'b0, 7'd3}},
    '{OP_INSERT,   -64'sd1,       1'b0, NO_RES},
    '{OP_INSERT,   64'sd1,        1'b0, NO_RES},
    '{OP_INSERT,   64'sh8000_0000_0000_0001, 1'b0, NO_RES},
    '{OP_INSERT,   64'sh7FFF_FFFF_FFFF_FFFE, 1'b0, NO_RES},
    '{OP_CONTAINS, 64'sh5555_5555_5555_5555, 1'b0, NO_RES},
    '{OP_INSERT,   64'shAAAA_AAAA_AAAA_AAAA, 1'b0, NO_RES},
    '{OP_ERASE,    64'sd0,        1'b0, NO_RES},
    '{OP_ERASE,    64'sd0,        1'b0, NO_RES},
    '{OP_ERASE,    KEY_MIN,       1'b1, '{1'b1, 6'd0, 1'b1, 1'b0, 7'd6}},
    '{OP_ERASE,    KEY_MAX,       1'b0, NO_RES},
    '{OP_CONTAINS, 64'sd1,        1'b0, NO_RES},
    '{OP_INSERT,   64'shFFFF_FFFF_0000_0000, 1'b0, NO_RES}
  };

  logic                 clk;
  logic                 rst_n;
  logic                 in_tvalid;
  logic                 in_tready;
  logic [InDataW-1:0]   in_tdata;
  logic                 out_tvalid;
  logic                 out_tready;
  logic [OutDataW-1:0]  out_tdata;

  logic signed [KeyW-1:0] held_keys [CAPACITY];
  int unsigned            held_count;
  logic signed [KeyW-1:0] key_pool [POOL_SIZE];
  set_result_t            pending_results [$];

  int unsigned errors;
  int unsigned words_sent;
  int unsigned results_seen;
  int unsigned n_hits;
  int unsigned n_changed;
  int unsigned n_rejects;

  sorted_key_set_top #(.CAPACITY(CAPACITY)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #6000000;
    $display("DONE: errors detected");
    $finish;
  end

  // Applies one operation to the model of the set and returns the result word it gives.
  function automatic set_result_t predict_set_op(input logic [OpW-1:0] op,
                                                 input logic signed [KeyW-1:0] key);
    set_result_t r;
    int unsigned lb;
    int unsigned i;
    r = '0;
    lb = 0;
    while (lb < held_count && held_keys[lb] < key) lb++;
    r.found = (lb < held_count) && (held_keys[lb] == key);
    if (r.found) r.position = lb[PosW-1:0];
    if (op == OP_INSERT && !r.found) begin
      if (held_count >= CAPACITY) begin
        r.full_reject = 1'b1;
      end else begin
        for (i = held_count; i > lb; i--) held_keys[i] = held_keys[i-1];
        held_keys[lb] = key;
        held_count++;
        r.changed = 1'b1;
      end
    end else if (op == OP_ERASE && r.found) begin
      for (i = lb; i + 1 < held_count; i++) held_keys[i] = held_keys[i+1];
      held_count--;
      r.changed = 1'b1;
    end
    r.count = held_count[CountW-1:0];
    return r;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [OpW-1:0] pick_op(input phase_kind_t kind);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 3) return OP_UNUSED;
    case (kind)
      PH_FILL: begin
        if (r < 78) return OP_INSERT;
        if (r < 90) return OP_CONTAINS;
        return OP_ERASE;
      end
      PH_DRAIN: begin
        if (r < 70) return OP_ERASE;
        if (r < 88) return OP_CONTAINS;
        return OP_INSERT;
      end
      default: begin
        if (r < 36) return OP_INSERT;
        if (r < 68) return OP_ERASE;
        return OP_CONTAINS;
      end
    endcase
  endfunction

  // Mostly keys already held or close neighbours of them, so that hits and misses both occur.
  function automatic logic signed [KeyW-1:0] pick_key();
    int unsigned r;
    logic signed [KeyW-1:0] k;
    r = $urandom_range(0, 99);
    if (r < 50 && held_count > 0) begin
      k = held_keys[$urandom_range(0, held_count - 1)];
    end else if (r < 58 && held_count > 0) begin
      k = held_keys[$urandom_range(0, held_count - 1)];
      k = $urandom_range(0, 1) ? k + 64'sd1 : k - 64'sd1;
    end else if (r < 85) begin
      k = key_pool[$urandom_range(0, POOL_SIZE - 1)];
    end else begin
      k = {$urandom, $urandom};
    end
    return k;
  endfunction

  task automatic send_word(input logic [OpW-1:0] op, input logic signed [KeyW-1:0] key,
                           input bit typed, input set_result_t typed_res,
                           input int unsigned gap);
    set_result_t pred;
    in_tdata  <= {{(InDataW - KeyW - OpW){1'b0}}, key, op};
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    pred = predict_set_op(op, key);
    pending_results.push_back(typed ? typed_res : pred);
    words_sent++;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_for_results();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic check_result(input logic [OutDataW-1:0] word);
    set_result_t want;
    set_result_t got;
    got.found       = word[0];
    got.position    = word[6:1];
    got.changed     = word[7];
    got.full_reject = word[8];
    got.count       = word[15:9];
    if (pending_results.size() == 0) begin
      $error("result word with no expectation waiting: %h", word);
      errors++;
      return;
    end
    want = pending_results.pop_front();
    if (got.found !== want.found) begin
      $error("found: expected %0d, got %0d", want.found, got.found);
      errors++;
    end
    if (got.position !== want.position) begin
      $error("position: expected %0d, got %0d", want.position, got.position);
      errors++;
    end
    if (got.changed !== want.changed) begin
      $error("changed: expected %0d, got %0d", want.changed, got.changed);
      errors++;
    end
    if (got.full_reject !== want.full_reject) begin
      $error("full_reject: expected %0d, got %0d", want.full_reject, got.full_reject);
      errors++;
    end
    if (got.count !== want.count) begin
      $error("count: expected %0d, got %0d", want.count, got.count);
      errors++;
    end
    n_hits    += want.found;
    n_changed += want.changed;
    n_rejects += want.full_reject;
  endtask

  // Result side: random stalls, steady stretches, and two long hold-offs that back up the input.
  initial begin
    int unsigned stall;
    int unsigned mode_cycles;
    bit steady;
    out_tready  = 1'b0;
    stall       = 0;
    mode_cycles = 0;
    steady      = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready) begin
        check_result(out_tdata);
        results_seen++;
        if (results_seen == 400 || results_seen == 1100) stall = HOLDOFF_CYCLES;
      end
      mode_cycles++;
      if (mode_cycles == 250) begin
        mode_cycles = 0;
        steady = ($urandom_range(0, 3) == 0);
      end
      if (stall > 0) begin
        out_tready <= 1'b0;
        stall--;
      end else begin
        out_tready <= 1'b1;
        if (!steady) stall = pick_gap();
      end
    end
  end

  initial begin
    int unsigned ph;
    int unsigned n;
    phase_kind_t kind;
    bit steady;
    logic [OpW-1:0] op;
    logic signed [KeyW-1:0] key;
    errors       = 0;
    words_sent   = 0;
    results_seen = 0;
    n_hits       = 0;
    n_changed    = 0;
    n_rejects    = 0;
    held_count   = 0;
    rst_n        = 1'b0;
    in_tvalid    = 1'b0;
    in_tdata     = '0;
    key_pool[0] = KEY_MIN;
    key_pool[1] = KEY_MAX;
    key_pool[2] = 64'sd0;
    key_pool[3] = -64'sd1;
    key_pool[4] = 64'sd1;
    key_pool[5] = KEY_MIN + 64'sd1;
    key_pool[6] = KEY_MAX - 64'sd1;
    for (n = 7; n < POOL_SIZE; n++) key_pool[n] = {$urandom, $urandom};
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (n = 0; n < NUM_DIRECTED; n++) begin
      send_word(DIRECTED[n].op, DIRECTED[n].key, DIRECTED[n].typed, DIRECTED[n].res,
                pick_gap());
    end

    for (ph = 0; ph < NUM_PHASES; ph++) begin
      if (ph % 4 == 3) wait_for_results();
      kind   = (ph == 0) ? PH_FILL : phase_kind_t'($urandom_range(0, 2));
      steady = ($urandom_range(0, 3) == 0);
      for (n = 0; n < PHASE_LEN; n++) begin
        // The opening phase inserts fresh keys until the store is full and refuses more.
        if (ph == 0) begin
          op  = (n % 10 == 9) ? OP_CONTAINS : OP_INSERT;
          key = {$urandom, $urandom};
        end else begin
          op  = pick_op(kind);
          key = pick_key();
        end
        send_word(op, key, 1'b0, NO_RES, steady ? 0 : pick_gap());
      end
    end

    wait_for_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Sent %0d words through fill, drain and mixed phases under random back-pressure.",
             words_sent);
    $display("Checked %0d results: %0d hits, %0d set changes, %0d refused on a full store.",
             results_seen, n_hits, n_changed, n_rejects);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+design
design/sks_pkg.sv
design/sks_ctrl.sv
design/sks_dp.sv
design/sorted_key_set_top.sv
tb/sv/tb.sv
